// File: rtl/cell_list_link_manager_core_macros.svh
// Assertion macros shared by the cell list link manager RTL.
// Each macro checks one implication at the rising clock edge, off during reset.
`ifndef CELL_LIST_LINK_MANAGER_CORE_MACROS_SVH
`define CELL_LIST_LINK_MANAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CLM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clm: same-cycle implication violated");
// Next-cycle implication
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clm: next-cycle implication violated");
`else
`define CLM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/clm_pkg.sv
`default_nettype none
package clm_pkg;

   // Geometry of the grid and the particle table
   localparam int MAX_PARTICLES = 1024;
   localparam int CELLS_X       = 32;
   localparam int CELLS_Y       = 32;
   localparam int CELL_COUNT    = CELLS_X * CELLS_Y;

   localparam int PART_W     = $clog2(MAX_PARTICLES);
   localparam int LINK_W     = PART_W + 1;
   localparam int CELL_IDX_W = $clog2(CELL_COUNT);
   localparam int COORD_W    = 5;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   // Empty head or missing link
   localparam logic [LINK_W-1:0] NIL = '1;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_MOVE   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REM_RD,
      ST_REM_WR,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_LNK,
      ST_FIN_RD,
      ST_FIN
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the accepted item
      logic clr_wr;   // write one empty head of the clearing pass
      logic rem_rd;   // read head of old cell and links of particle
      logic rem_wr;   // unlink particle from old cell
      logic ins_rd;   // read head of new cell
      logic ins_wr;   // push particle at head of new cell
      logic ins_lnk;  // back-link the former head to the particle
      logic fin_rd;   // read head of target cell and links of particle
      logic fin_cap;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;  // clearing pass writes its last head
      logic out_free;  // result register can take a new result
   } sts_type;

   // A link names a particle unless it is the empty mark
   function automatic logic link_valid(input logic [LINK_W-1:0] v);
      return !v[LINK_W-1];
   endfunction

   // Saturate the coordinates and flatten them to a head address
   function automatic logic [CELL_IDX_W-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                        input logic [COORD_W-1:0] y);
      logic [CELL_IDX_W-1:0] xs;
      logic [CELL_IDX_W-1:0] ys;
      xs = CELL_IDX_W'(x);
      ys = CELL_IDX_W'(y);
      if (xs > CELL_IDX_W'(CELLS_X - 1)) xs = CELL_IDX_W'(CELLS_X - 1);
      if (ys > CELL_IDX_W'(CELLS_Y - 1)) ys = CELL_IDX_W'(CELLS_Y - 1);
      return CELL_IDX_W'(xs * CELL_IDX_W'(CELLS_Y) + ys);
   endfunction

endpackage
`default_nettype wire

// File: rtl/clm_ctrl.sv
`default_nettype none
module clm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire clm_pkg::kind_type req_kind,
   input  wire clm_pkg::sts_type  sts,
   output clm_pkg::cmd_type       cmd
);
   import clm_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   // Hold state and the kind of the item in work
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff  <= KIND_QUERY;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Sequence the reads and writes of one item
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               kind_in  = req_kind;
               unique case (req_kind)
                  KIND_INSERT: state_in = ST_INS_RD;
                  KIND_REMOVE: state_in = ST_REM_RD;
                  KIND_MOVE:   state_in = ST_REM_RD;
                  KIND_QUERY:  state_in = ST_FIN_RD;
                  default:     state_in = ST_FIN_RD;
               endcase
            end
         end
         ST_REM_RD: begin
            cmd.rem_rd = 1'b1;
            state_in   = ST_REM_WR;
         end
         ST_REM_WR: begin
            cmd.rem_wr = 1'b1;
            state_in   = (kind_ff == KIND_MOVE) ? ST_INS_RD : ST_FIN_RD;
         end
         ST_INS_RD: begin
            cmd.ins_rd = 1'b1;
            state_in   = ST_INS_WR;
         end
         ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            state_in   = ST_INS_LNK;
         end
         ST_INS_LNK: begin
            cmd.ins_lnk = 1'b1;
            state_in    = ST_FIN_RD;
         end
         ST_FIN_RD: begin
            cmd.fin_rd = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin_cap = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/clm_dpath.sv
`default_nettype none
module clm_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire clm_pkg::cmd_type             cmd,
   output clm_pkg::sts_type                  sts,
   input  wire clm_pkg::kind_type            req_kind,
   input  wire logic [clm_pkg::PART_W-1:0]   req_particle,
   input  wire logic [clm_pkg::COORD_W-1:0]  req_old_cell_x,
   input  wire logic [clm_pkg::COORD_W-1:0]  req_old_cell_y,
   input  wire logic [clm_pkg::COORD_W-1:0]  req_new_cell_x,
   input  wire logic [clm_pkg::COORD_W-1:0]  req_new_cell_y,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [clm_pkg::LINK_W-1:0]        rsp_cell_head,
   output logic [clm_pkg::LINK_W-1:0]        rsp_particle_prev,
   output logic [clm_pkg::LINK_W-1:0]        rsp_particle_next
);
   import clm_pkg::*;

   // Head, prev and next stores
   logic [LINK_W-1:0] head_mem [CELL_COUNT];
   logic [LINK_W-1:0] prev_mem [MAX_PARTICLES];
   logic [LINK_W-1:0] next_mem [MAX_PARTICLES];

   // Captured item
   logic [PART_W-1:0]     part_ff;
   logic [CELL_IDX_W-1:0] oc_ff;
   logic [CELL_IDX_W-1:0] nc_ff;
   logic [CELL_IDX_W-1:0] tc_ff;
   logic [CELL_IDX_W-1:0] oc_in;
   logic [CELL_IDX_W-1:0] nc_in;

   // Registered read data
   logic [LINK_W-1:0] head_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic [LINK_W-1:0] next_rd_ff;

   // Clearing pass counter
   logic [CELL_IDX_W-1:0] clr_cnt_ff;

   // Result register
   logic              out_valid_ff, out_valid_in;
   logic [LINK_W-1:0] out_head_ff;
   logic [LINK_W-1:0] out_prev_ff;
   logic [LINK_W-1:0] out_next_ff;

   // Read and write ports
   logic                  head_we;
   logic [CELL_IDX_W-1:0] head_wa;
   logic [LINK_W-1:0]     head_wd;
   logic [CELL_IDX_W-1:0] head_ra;
   logic                  prev_we;
   logic [PART_W-1:0]     prev_wa;
   logic [LINK_W-1:0]     prev_wd;
   logic                  next_we;
   logic [PART_W-1:0]     next_wa;
   logic [LINK_W-1:0]     next_wd;
   logic                  head_hit;
   logic [LINK_W-1:0]     part_link;

   assign oc_in     = cell_index(req_old_cell_x, req_old_cell_y);
   assign nc_in     = cell_index(req_new_cell_x, req_new_cell_y);
   assign part_link = LINK_W'(part_ff);
   assign head_hit  = (head_rd_ff == part_link);

   // Capture the item on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         part_ff <= req_particle;
         oc_ff   <= oc_in;
         nc_ff   <= nc_in;
         tc_ff   <= (req_kind == KIND_REMOVE) ? oc_in : nc_in;
      end
   end

   // Advance the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // Select head read address
   always_comb begin
      priority if (cmd.rem_rd) head_ra = oc_ff;
      else if (cmd.ins_rd)     head_ra = nc_ff;
      else                     head_ra = tc_ff;
   end

   // Select the writes of each step; the former head sits in head_rd_ff
   always_comb begin
      head_we = 1'b0;
      head_wa = nc_ff;
      head_wd = part_link;
      prev_we = 1'b0;
      prev_wa = part_ff;
      prev_wd = NIL;
      next_we = 1'b0;
      next_wa = part_ff;
      next_wd = head_rd_ff;
      priority if (cmd.clr_wr) begin
         head_we = 1'b1;
         head_wa = clr_cnt_ff;
         head_wd = NIL;
      end else if (cmd.rem_wr) begin
         head_we = head_hit;
         head_wa = oc_ff;
         head_wd = next_rd_ff;
         prev_we = link_valid(next_rd_ff);
         prev_wa = next_rd_ff[PART_W-1:0];
         prev_wd = head_hit ? NIL : prev_rd_ff;
         next_we = !head_hit && link_valid(prev_rd_ff);
         next_wa = prev_rd_ff[PART_W-1:0];
         next_wd = next_rd_ff;
      end else if (cmd.ins_wr) begin
         head_we = 1'b1;
         prev_we = 1'b1;
         next_we = 1'b1;
      end else if (cmd.ins_lnk) begin
         prev_we = link_valid(head_rd_ff);
         prev_wa = head_rd_ff[PART_W-1:0];
         prev_wd = part_link;
      end else begin
         head_we = 1'b0;
      end
   end

   // Write and read the head store
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (cmd.rem_rd || cmd.ins_rd || cmd.fin_rd) head_rd_ff <= head_mem[head_ra];
   end

   // Write and read the prev store
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (cmd.rem_rd || cmd.fin_rd) prev_rd_ff <= prev_mem[part_ff];
   end

   // Write and read the next store
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (cmd.rem_rd || cmd.fin_rd) next_rd_ff <= next_mem[part_ff];
   end

   // Hold the result until taken
   always_comb begin
      priority if (cmd.fin_cap) out_valid_in = 1'b1;
      else if (rsp_tready)      out_valid_in = 1'b0;
      else                      out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_cap) begin
         out_head_ff <= head_rd_ff;
         out_prev_ff <= prev_rd_ff;
         out_next_ff <= next_rd_ff;
      end
   end

   assign sts.clr_last = cmd.clr_wr && (clr_cnt_ff == CELL_IDX_W'(CELL_COUNT - 1));
   assign sts.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_cell_head     = out_head_ff;
   assign rsp_particle_prev = out_prev_ff;
   assign rsp_particle_next = out_next_ff;

endmodule
`default_nettype wire

// File: rtl/cell_list_link_manager_core.sv
// Cell list link manager: keeps one head per grid cell and prev/next links
// per particle, and serves insert, remove, move and query items.
// Input channel req_*: tuser carries the kind, tdata the particle and the
// old and new cell coordinates. Result channel rsp_*: one item per input
// item, giving the target cell head and the particle links (-1 for none).
// After reset the block runs a clearing pass over the 1024 cell heads,
// one head per cycle, and takes no item until the pass is done.
// Items are worked one at a time by a sequencer over single-port head,
// prev and next stores with registered reads; the number of dependent
// store accesses sets the time per item. A remove reads and unlinks, an
// insert reads the new cell head, pushes and back-links, a move does both,
// and every kind ends with a read of the target cell and a capture into
// the result register, then returns to idle before the next item.
// The finished result waits in an output register while the sequencer
// takes and works one more item; while the receiver stalls, that item
// holds in its last step until the register frees, and no further item
// is taken.
`default_nettype none
`include "cell_list_link_manager_core_macros.svh"
module cell_list_link_manager_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [9:0] particle, [14:10] old_cell_x, [19:15] old_cell_y,
   // [24:20] new_cell_x, [29:25] new_cell_y, [31:30] zero
   input  wire logic [clm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] kind
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [10:0] cell_head, [21:11] particle_prev, [32:22] particle_next,
   // [39:33] zero
   output logic [clm_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);
   import clm_pkg::*;

   cmd_type           cmd;
   sts_type           sts;
   kind_type          req_kind;
   logic [LINK_W-1:0] rsp_cell_head;
   logic [LINK_W-1:0] rsp_particle_prev;
   logic [LINK_W-1:0] rsp_particle_next;

   assign req_kind = kind_type'(req_tuser);

   clm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .sts        (sts),
      .cmd        (cmd)
   );

   clm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_particle      (req_tdata[9:0]),
      .req_old_cell_x    (req_tdata[14:10]),
      .req_old_cell_y    (req_tdata[19:15]),
      .req_new_cell_x    (req_tdata[24:20]),
      .req_new_cell_y    (req_tdata[29:25]),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_cell_head     (rsp_cell_head),
      .rsp_particle_prev (rsp_particle_prev),
      .rsp_particle_next (rsp_particle_next)
   );

   // Pack the result
   assign rsp_tdata = {7'd0, rsp_particle_next, rsp_particle_prev, rsp_cell_head};

   // No item enters during the clearing pass
   `CLM_ASSERT_IMP(a_no_accept_in_clear, clock, reset, cmd.clr_wr, !req_tready)
   // One item at a time: no accept right after an accept
   `CLM_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // A captured result shows on the result channel
   `CLM_ASSERT_NEXT(a_cap_shows, clock, reset, cmd.fin_cap, rsp_tvalid)

endmodule
`default_nettype wire

// File: tb/tb_cell_list_link_manager_core.sv
`timescale 1ns / 1ps
module tb_cell_list_link_manager_core;
   import clm_pkg::*;

   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 700;
   // no item moves during the clearing pass after reset
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_ITEMS   = 80;
   localparam int TAIL_CYCLES  = 20;

   // One operation as the sender sees it
   typedef struct {
      kind_type         kind;
      logic [PART_W-1:0] particle;
      logic [COORD_W-1:0] old_x;
      logic [COORD_W-1:0] old_y;
      logic [COORD_W-1:0] new_x;
      logic [COORD_W-1:0] new_y;
      bit               drain;  // hold until all results are back
   } cell_op_t;

   // Result item, laid out as on rsp_tdata (head in the lowest bits)
   typedef struct packed {
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] head;
   } link_view_t;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = KIND_INSERT;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   cell_list_link_manager_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow of the head and link stores
   logic [LINK_W-1:0] head_mem [CELL_COUNT];
   logic [LINK_W-1:0] prev_mem [MAX_PARTICLES];
   logic [LINK_W-1:0] next_mem [MAX_PARTICLES];

   // Stimulus-side bookkeeping: cell each particle is listed in, or -1
   int home_of [MAX_PARTICLES];
   bit placed [MAX_PARTICLES];
   int members_q[$];

   cell_op_t   pending_ops_q[$];
   link_view_t expected_links_q[$];
   cell_op_t   op_in_flight;

   int sent_count = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int send_mode = 0;
   int sink_gap = 0;
   int sink_mode = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one operation to the shadow lists and return what the block reports.
   // Particle indices are 10 bits, so every index is in range, and 5-bit
   // coordinates never need saturation: the cell address is just {x, y}.
   function automatic link_view_t update_cell_lists(cell_op_t op);
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] nxt;
      logic [LINK_W-1:0] prv;
      logic [LINK_W-1:0] old_head;
      logic [CELL_IDX_W-1:0] oc;
      logic [CELL_IDX_W-1:0] nc;
      logic [CELL_IDX_W-1:0] tc;
      link_view_t view;
      p = {1'b0, op.particle};
      oc = {op.old_x, op.old_y};
      nc = {op.new_x, op.new_y};
      tc = (op.kind == KIND_REMOVE) ? oc : nc;
      // unlink through the head or through the prev link; drop writes via -1
      if (op.kind == KIND_REMOVE || op.kind == KIND_MOVE) begin
         nxt = next_mem[op.particle];
         if (head_mem[oc] == p) begin
            head_mem[oc] = nxt;
            if (!nxt[LINK_W-1]) prev_mem[nxt[PART_W-1:0]] = NIL;
         end else begin
            prv = prev_mem[op.particle];
            if (!prv[LINK_W-1]) next_mem[prv[PART_W-1:0]] = nxt;
            if (!nxt[LINK_W-1]) prev_mem[nxt[PART_W-1:0]] = prv;
         end
      end
      // push at the head of the new cell
      if (op.kind == KIND_INSERT || op.kind == KIND_MOVE) begin
         old_head = head_mem[nc];
         head_mem[nc] = p;
         prev_mem[op.particle] = NIL;
         next_mem[op.particle] = old_head;
         if (!old_head[LINK_W-1]) prev_mem[old_head[PART_W-1:0]] = p;
      end
      view.head = head_mem[tc];
      view.prev = prev_mem[op.particle];
      view.next = next_mem[op.particle];
      return view;
   endfunction

   function automatic int cell_at(int x, int y);
      return x * CELLS_Y + y;
   endfunction

   // Mostly a few crowded cells so that lists grow deep
   function automatic int pick_cell();
      int hot_cells [4];
      hot_cells = '{0, 1023, 341, 682};
      if ($urandom_range(0, 9) < 7) return hot_cells[$urandom_range(0, 3)];
      return $urandom_range(0, CELL_COUNT - 1);
   endfunction

   function automatic bit start_idle_burst(int mode);
      case (mode)
         1: return $urandom_range(0, 7) == 0;
         2: return $urandom_range(0, 2) == 0;
         default: return 1'b0;
      endcase
   endfunction

   // Queue one operation and track where the particle should now be listed
   task automatic plan_op(kind_type k, int p, int oc, int nc, bit drain);
      cell_op_t op;
      int idx;
      op.kind = k;
      op.particle = PART_W'(p);
      op.old_x = COORD_W'(oc >> COORD_W);
      op.old_y = COORD_W'(oc);
      op.new_x = COORD_W'(nc >> COORD_W);
      op.new_y = COORD_W'(nc);
      op.drain = drain;
      pending_ops_q.push_back(op);
      case (k)
         KIND_INSERT, KIND_MOVE: begin
            if (k == KIND_INSERT || home_of[p] != oc) begin
               if (home_of[p] < 0) members_q.push_back(p);
            end
            home_of[p] = nc;
            placed[p] = 1'b1;
         end
         KIND_REMOVE: begin
            if (home_of[p] == oc) begin
               home_of[p] = -1;
               for (idx = 0; idx < members_q.size(); idx++) begin
                  if (members_q[idx] == p) begin
                     members_q.delete(idx);
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Feed the input channel from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= KIND_INSERT;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_links_q.push_back(update_cell_lists(op_in_flight));
            sent_count++;
            if (sent_count % 50 == 0) send_mode = $urandom_range(0, 2);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_ops_q[0].drain && expected_links_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (hold_left == 0 && pending_ops_q.size() > TAIL_ITEMS &&
                         start_idle_burst(send_mode)) begin
               send_gap = $urandom_range(0, 15);
               req_tvalid <= 1'b0;
            end else begin
               op_in_flight = pending_ops_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, op_in_flight.new_y, op_in_flight.new_x,
                             op_in_flight.old_y, op_in_flight.old_x, op_in_flight.particle};
               req_tuser <= op_in_flight.kind;
            end
         end
      end
   end

   // Take results, compare against the oldest expectation, and pace tready
   always @(posedge clock) begin
      link_view_t got;
      link_view_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[3*LINK_W-1:0];
            results_seen++;
            if (results_seen % 50 == 0) sink_mode = $urandom_range(0, 2);
            if (expected_links_q.size() == 0) begin
               $error("result item with nothing outstanding: %h", got);
               mismatch_count++;
            end else begin
               want = expected_links_q.pop_front();
               if (got.head !== want.head) begin
                  $error("cell_head: expected %0d, actual %0d",
                         $signed(want.head), $signed(got.head));
                  mismatch_count++;
               end
               if (got.prev !== want.prev) begin
                  $error("particle_prev: expected %0d, actual %0d",
                         $signed(want.prev), $signed(got.prev));
                  mismatch_count++;
               end
               if (got.next !== want.next) begin
                  $error("particle_next: expected %0d, actual %0d",
                         $signed(want.next), $signed(got.next));
                  mismatch_count++;
               end
            end
         end
         // one long hold-off lets the block back up into the input channel
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 120) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else if (pending_ops_q.size() > TAIL_ITEMS && start_idle_burst(sink_mode)) begin
            sink_gap = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Count cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int i;
      int r;
      int p;
      int c;
      bit late;
      for (i = 0; i < CELL_COUNT; i++) head_mem[i] = NIL;
      for (i = 0; i < MAX_PARTICLES; i++) begin
         prev_mem[i] = '0;
         next_mem[i] = '0;
         home_of[i] = -1;
         placed[i] = 1'b0;
      end

      // Directed: corner cells and indices, head, middle and tail unlinks
      plan_op(KIND_INSERT, 0, cell_at(31, 31), cell_at(0, 0), 1'b0);
      plan_op(KIND_INSERT, 1023, 0, cell_at(0, 0), 1'b0);
      plan_op(KIND_INSERT, 5, 0, cell_at(31, 31), 1'b0);
      plan_op(KIND_QUERY, 0, 0, cell_at(0, 0), 1'b0);
      plan_op(KIND_QUERY, 1023, 0, cell_at(31, 31), 1'b0);
      plan_op(KIND_MOVE, 0, cell_at(0, 0), cell_at(31, 31), 1'b0);
      plan_op(KIND_REMOVE, 5, cell_at(31, 31), 0, 1'b0);
      plan_op(KIND_INSERT, 5, 0, cell_at(31, 0), 1'b0);
      plan_op(KIND_INSERT, 600, 0, cell_at(31, 0), 1'b0);
      plan_op(KIND_INSERT, 341, 0, cell_at(31, 0), 1'b0);
      plan_op(KIND_REMOVE, 600, cell_at(31, 0), 0, 1'b0);
      plan_op(KIND_REMOVE, 341, cell_at(31, 0), 0, 1'b0);
      plan_op(KIND_REMOVE, 5, cell_at(31, 0), 0, 1'b0);
      // remove a particle that is in no list; its stale links are both -1
      plan_op(KIND_REMOVE, 5, cell_at(0, 31), 0, 1'b0);
      plan_op(KIND_QUERY, 5, 0, cell_at(31, 0), 1'b0);
      plan_op(KIND_MOVE, 1023, cell_at(0, 0), cell_at(0, 0), 1'b0);
      plan_op(KIND_MOVE, 0, cell_at(31, 31), cell_at(0, 0), 1'b0);
      plan_op(KIND_QUERY, 1023, cell_at(31, 31), cell_at(0, 0), 1'b0);
      plan_op(KIND_INSERT, 682, 0, cell_at(21, 10), 1'b0);
      plan_op(KIND_QUERY, 682, 0, cell_at(10, 21), 1'b0);
      plan_op(KIND_INSERT, 341, 0, cell_at(10, 21), 1'b0);

      // Random: well-formed list traffic; corrupting noise only near the end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(0, 99);
         late = (i >= RANDOM_ITEMS - 120);
         if (members_q.size() == 0 || r < 35) begin
            if (late && r < 8 && members_q.size() != 0) begin
               p = members_q[$urandom_range(0, members_q.size() - 1)];
            end else begin
               do p = $urandom_range(0, MAX_PARTICLES - 1); while (home_of[p] >= 0);
            end
            plan_op(KIND_INSERT, p, $urandom_range(0, CELL_COUNT - 1), pick_cell(),
                    i == 0 || i == 350);
         end else if (r < 80) begin
            p = members_q[$urandom_range(0, members_q.size() - 1)];
            c = (late && r[0]) ? pick_cell() : home_of[p];
            plan_op((r < 55) ? KIND_REMOVE : KIND_MOVE, p, c, pick_cell(),
                    i == 0 || i == 350);
         end else begin
            if (r < 90) begin
               p = members_q[$urandom_range(0, members_q.size() - 1)];
               c = home_of[p];
            end else begin
               do p = $urandom_range(0, MAX_PARTICLES - 1); while (!placed[p]);
               c = pick_cell();
            end
            plan_op(KIND_QUERY, p, $urandom_range(0, CELL_COUNT - 1), c,
                    i == 0 || i == 350);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Run until every item has been answered or the channels go quiet
      while ((pending_ops_q.size() != 0 || req_tvalid || expected_links_q.size() != 0) &&
             quiet_cycles < QUIET_LIMIT)
         @(posedge clock);

      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_cell_list_link_manager_core failed");
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
         if (mismatch_count == 0 && expected_links_q.size() == 0)
            $display("tb_cell_list_link_manager_core passed");
         else
            $display("tb_cell_list_link_manager_core failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/clm_pkg.sv
rtl/clm_ctrl.sv
rtl/clm_dpath.sv
rtl/cell_list_link_manager_core.sv
tb/tb_cell_list_link_manager_core.sv
